@@ rtl/utf8_to_utf16_decoder_defines.svh @@
// assertion macros for the utf8 to utf16 decoder
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define U8U16_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// consequence holds in the same cycle as the condition
`define U8U16_ASSERT_IMPLY(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("assertion failed");

// consequence holds in the cycle after the condition
`define U8U16_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define U8U16_ASSERT_ALWAYS(label, clk, rstn, expr)
`define U8U16_ASSERT_IMPLY(label, clk, rstn, cond, cons)
`define U8U16_ASSERT_NEXT(label, clk, rstn, cond, cons)

`endif

`endif

@@ rtl/u8u16_pkg.sv @@
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] SURR_HI     = 16'hD800;
    localparam logic [15:0] SURR_LO     = 16'hDC00;
    localparam logic [30:0] SURR_FIRST  = 31'h0000D800;
    localparam logic [30:0] SURR_LAST   = 31'h0000DFFF;
    localparam logic [30:0] PLANE1_BASE = 31'h00010000;
    localparam logic [30:0] UNICODE_MAX = 31'h0010FFFF;
    localparam logic [30:0] BMP_MAX     = 31'h0000FFFF;

    // one code unit with its replacement flag
    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
    } unit_t;

    // one result item as held in the output buffer
    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } result_t;

    // outcome of decoding a byte with no sequence open
    typedef struct packed {
        logic        emit;
        unit_t       unit;
        logic        opens;
        logic [2:0]  rem;
        logic [2:0]  cls;
        logic [30:0] acc;
    } idle_t;

    // outcome of a completed sequence
    typedef struct packed {
        logic  pair;
        unit_t u0;
        unit_t u1;
    } fin_t;

    // smallest legal value for each sequence length, clamped above class 4
    function automatic logic [30:0] min_value(input logic [2:0] cls);
        logic [30:0] m;
        case (cls)
            3'd0: m = 31'h00000080;
            3'd1: m = 31'h00000800;
            3'd2: m = 31'h00010000;
            3'd3: m = 31'h00200000;
            default: m = 31'h04000000;
        endcase
        return m;
    endfunction

    function automatic idle_t idle_decode(input logic [7:0] b);
        idle_t r;
        r = '0;
        if (b[7] == 1'b0) begin
            r.emit = 1'b1;
            r.unit = '{code_unit: {8'h00, b}, is_replacement: 1'b0};
        end else if (b[6] == 1'b0 || b[7:1] == 7'b1111111) begin
            // stray continuation, or FE / FF
            r.emit = 1'b1;
            r.unit = '{code_unit: REPL_UNIT, is_replacement: 1'b1};
        end else begin
            r.opens = 1'b1;
            if (b[7:2] == 6'b111111) begin
                r.rem = 3'd5; r.cls = 3'd4; r.acc = {30'd0, b[0]};
            end else if (b[7:3] == 5'b11111) begin
                r.rem = 3'd4; r.cls = 3'd3; r.acc = {29'd0, b[1:0]};
            end else if (b[7:4] == 4'b1111) begin
                r.rem = 3'd3; r.cls = 3'd2; r.acc = {28'd0, b[2:0]};
            end else if (b[7:5] == 3'b111) begin
                r.rem = 3'd2; r.cls = 3'd1; r.acc = {27'd0, b[3:0]};
            end else begin
                r.rem = 3'd1; r.cls = 3'd0; r.acc = {26'd0, b[4:0]};
            end
        end
        return r;
    endfunction

    function automatic fin_t finish_seq(input logic [30:0] v, input logic [2:0] cls);
        fin_t        f;
        logic [30:0] s;
        f = '0;
        s = v - PLANE1_BASE;
        if (v < min_value(cls) || (v >= SURR_FIRST && v <= SURR_LAST)) begin
            f.u0 = '{code_unit: REPL_UNIT, is_replacement: 1'b1};
        end else if (v >= PLANE1_BASE && v <= UNICODE_MAX) begin
            f.pair = 1'b1;
            f.u0 = '{code_unit: SURR_HI | {6'd0, s[19:10]}, is_replacement: 1'b0};
            f.u1 = '{code_unit: SURR_LO | {6'd0, s[9:0]}, is_replacement: 1'b0};
        end else if (v > BMP_MAX) begin
            f.u0 = '{code_unit: REPL_UNIT, is_replacement: 1'b1};
        end else begin
            f.u0 = '{code_unit: v[15:0], is_replacement: 1'b0};
        end
        return f;
    endfunction

endpackage

@@ rtl/utf8_to_utf16_decoder.sv @@
// UTF-8 to UTF-16 decoder: takes one UTF-8 byte per input item and gives zero, one or two
// UTF-16 code units (high surrogate first for pairs), with U+FFFD and the tuser flag for
// ill-formed input and tlast on the final unit caused by each byte. A byte is registered on
// entry, decoded combinationally into a two-entry output buffer, and read out one code unit
// per cycle while m_tready is high. Throughput is one byte per cycle while the output is not
// stalled; a byte that gives two units (a surrogate pair, or a U+FFFD for a broken sequence
// followed by the byte decoded afresh) holds the decode stage while the single output port
// drains the buffer. Bytes that only extend a sequence give no output.
`include "utf8_to_utf16_decoder_defines.svh"

module utf8_to_utf16_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tuser,   // [0] is_replacement
    output logic        m_tlast    // last_of_run
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // decoder state
    logic [2:0]  rem_reg, rem_next;
    logic [2:0]  cls_reg, cls_next;
    logic [30:0] acc_reg, acc_next;

    // output buffer
    u8u16_pkg::result_t slot0_reg, slot1_reg;
    logic [1:0]         cnt_reg;

    u8u16_pkg::unit_t   r0, r1;
    u8u16_pkg::idle_t   idle;
    u8u16_pkg::fin_t    fin;
    logic [30:0]        acc_cont;
    logic [1:0]         n_res;
    logic               out_free;
    logic               load;
    logic               m_take;

    // handshake
    assign m_take   = m_tvalid && m_tready;
    assign out_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign load     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || load;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = slot0_reg.code_unit;
    assign m_tuser  = slot0_reg.is_replacement;
    assign m_tlast  = slot0_reg.last_of_run;

    // decode of the registered byte against the sequence state
    always_comb begin
        idle     = u8u16_pkg::idle_decode(in_byte_reg);
        acc_cont = {acc_reg[24:0], in_byte_reg[5:0]};
        fin      = u8u16_pkg::finish_seq(acc_cont, cls_reg);
        rem_next = rem_reg;
        cls_next = cls_reg;
        acc_next = acc_reg;
        n_res    = 2'd0;
        r0       = '0;
        r1       = '0;
        if (rem_reg != 3'd0) begin
            if (in_byte_reg[7:6] == 2'b10) begin
                acc_next = acc_cont;
                rem_next = rem_reg - 3'd1;
                if (rem_reg == 3'd1) begin
                    r0    = fin.u0;
                    r1    = fin.u1;
                    n_res = fin.pair ? 2'd2 : 2'd1;
                end
            end else begin
                // sequence cut short: replacement, then decode the byte afresh
                r0       = '{code_unit: u8u16_pkg::REPL_UNIT, is_replacement: 1'b1};
                rem_next = 3'd0;
                if (idle.emit) begin
                    r1    = idle.unit;
                    n_res = 2'd2;
                end else begin
                    n_res = 2'd1;
                end
                if (idle.opens) begin
                    rem_next = idle.rem;
                    cls_next = idle.cls;
                    acc_next = idle.acc;
                end
            end
        end else begin
            if (idle.emit) begin
                r0    = idle.unit;
                n_res = 2'd1;
            end
            if (idle.opens) begin
                rem_next = idle.rem;
                cls_next = idle.cls;
                acc_next = idle.acc;
            end
        end
    end

    // input register and decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            rem_reg      <= 3'd0;
            cls_reg      <= 3'd0;
            acc_reg      <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (load) begin
                rem_reg <= rem_next;
                cls_reg <= cls_next;
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // output buffer count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= n_res;
        end else if (m_take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // output buffer payload
    always_ff @(posedge aclk) begin
        if (load) begin
            slot0_reg <= '{code_unit: r0.code_unit, is_replacement: r0.is_replacement,
                           last_of_run: (n_res == 2'd1)};
            slot1_reg <= '{code_unit: r1.code_unit, is_replacement: r1.is_replacement,
                           last_of_run: 1'b1};
        end else if (m_take) begin
            slot0_reg <= slot1_reg;
        end
    end

    // checks
    `U8U16_ASSERT_ALWAYS(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3)
    `U8U16_ASSERT_IMPLY(a_pair_first_not_last, aclk, aresetn, cnt_reg == 2'd2, !slot0_reg.last_of_run)
    `U8U16_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_take && !m_tlast, m_tvalid)
    `U8U16_ASSERT_IMPLY(a_rem_fits_class, aclk, aresetn, rem_reg != 3'd0, {1'b0, rem_reg} <= ({1'b0, cls_reg} + 4'd1))
    `U8U16_ASSERT_IMPLY(a_no_load_on_full, aclk, aresetn, cnt_reg == 2'd2, !load)

endmodule
